// ===== rtl/aescts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescts_pkg
// Shared types, constants and AES round functions for the CBC-CS3 cipher.
// ----------------------------------------------------------------------------
package aescts_pkg;

  localparam int unsigned Rounds = 10;
  localparam logic [3:0]  ROUNDS_C = 4'(Rounds);
  localparam logic [4:0]  FULL_BYTES = 5'd16;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY_HI = 3'd0;
  localparam logic [2:0] CFG_KEY_LO = 3'd1;
  localparam logic [2:0] CFG_IV_HI  = 3'd2;
  localparam logic [2:0] CFG_IV_LO  = 3'd3;
  localparam logic [2:0] CFG_DIR    = 3'd4;

  typedef enum logic [1:0] {
    OUT_ONE,
    OUT_TWO,
    OUT_ERR
  } out_sel_e;

  typedef enum logic [1:0] {
    CH_KEEP,
    CH_AFTER,
    CH_IV
  } chain_sel_e;

  typedef struct packed {
    logic       kx_en;
    logic [3:0] step;
    logic       in_take;
    logic       held_in;
    logic       load1;
    logic       load2;
    logic       round;
    logic       last;
    logic       out_load;
    out_sel_e   out_sel;
    chain_sel_e chain_sel;
    logic       held_cur;
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] rcon_f(logic [3:0] i);
    logic [7:0] v;
    case (i)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of a block, byte 0 in the top bits
  function automatic logic [7:0] byte_of(logic [127:0] s, int k);
    return s[127-8*k -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[127-8*(c*4+w) -: 8] = SBOX[byte_of(s, ((c + w) & 3) * 4 + w)];
    return t;
  endfunction

  function automatic logic [127:0] inv_sub_shift(logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[127-8*(((c + w) & 3) * 4 + w) -: 8] = INV_SBOX[byte_of(s, c*4+w)];
    return t;
  endfunction

  function automatic logic [127:0] mix(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(s, c*4);
      a1 = byte_of(s, c*4+1);
      a2 = byte_of(s, c*4+2);
      a3 = byte_of(s, c*4+3);
      t[127-8*(c*4)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[127-8*(c*4+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[127-8*(c*4+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[127-8*(c*4+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]  = byte_of(s, c*4+j);
        x2[j] = xt(a[j]);
        x4[j] = xt(x2[j]);
        x8[j] = xt(x4[j]);
        m9[j] = x8[j] ^ a[j];
        mb[j] = x8[j] ^ x2[j] ^ a[j];
        md[j] = x8[j] ^ x4[j] ^ a[j];
        me[j] = x8[j] ^ x4[j] ^ x2[j];
      end
      t[127-8*(c*4)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      t[127-8*(c*4+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      t[127-8*(c*4+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      t[127-8*(c*4+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    return t;
  endfunction

  function automatic logic [127:0] key_next(logic [127:0] k, logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // keep the leading n bytes
  function automatic logic [127:0] byte_mask(logic [4:0] n);
    logic [127:0] m;
    for (int i = 0; i < 16; i++)
      m[127-8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
    return m;
  endfunction

endpackage

// ===== rtl/aes128_cbc_cts_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_cbc_cts_cipher
// AES-128 CBC with always-swap ciphertext stealing over a beat stream.
// ----------------------------------------------------------------------------
// A beat that pushes a held block out is loaded, run through ten rounds of the
// single iterative round unit and output. A final beat takes the two AES passes
// and two output beats; a first beat is only held.
// After reset and after each key write the round key store is swept, during
// which no beat is accepted.
// ----------------------------------------------------------------------------
module aes128_cbc_cts_cipher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // block_high[63:0], block_low[127:64], byte_count[132:128], zero fill
  input  logic [135:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // data_high[63:0], data_low[127:64], valid_bytes[132:128], zero fill
  output logic [135:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  // status[0]
  output logic [0:0]   m_axis_tuser_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);

  aescts_pkg::dp_cmd_t cmd;
  logic [127:0] out_data;
  logic [4:0]   out_bytes;

  aescts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cmd_o       (cmd)
  );

  aescts_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    ({s_axis_tdata_i[63:0], s_axis_tdata_i[127:64]}),
    .in_count_i   (s_axis_tdata_i[132:128]),
    .out_data_o   (out_data),
    .out_bytes_o  (out_bytes),
    .out_eom_o    (m_axis_tlast_o),
    .out_status_o (m_axis_tuser_o[0])
  );

  assign m_axis_tdata_o = {3'b000, out_bytes, out_data[63:0], out_data[127:64]};

endmodule

// ===== rtl/aescts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescts_ctrl
// Sequencer: key expansion sweep, round count, CTS pass order, output beats.
// ----------------------------------------------------------------------------
module aescts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  output aescts_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_KEXP,
    S_IDLE,
    S_ROUND,
    S_DONE,
    S_EMIT2,
    S_ERR
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       fin_q, fin_d;
  logic       pass_q, pass_d;
  logic       hv_q, hv_d;
  logic       ov_q, ov_d;
  logic       out_free, accept, key_wr;

  assign out_free    = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign key_wr      = cfg_we_i &&
                       (cfg_idx_i == aescts_pkg::CFG_KEY_HI ||
                        cfg_idx_i == aescts_pkg::CFG_KEY_LO);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    pass_d  = pass_q;
    hv_d    = hv_q;
    cmd_o   = '0;
    cmd_o.out_sel   = aescts_pkg::OUT_ONE;
    cmd_o.chain_sel = aescts_pkg::CH_KEEP;
    case (state_q)
      S_KEXP: begin
        cmd_o.kx_en = 1'b1;
        cmd_o.step  = cnt_q;
        if (cnt_q == aescts_pkg::ROUNDS_C) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.in_take = 1'b1;
          fin_d  = in_last_i;
          pass_d = 1'b0;
          cnt_d  = 4'd1;
          if (!hv_q) begin
            if (in_last_i) begin
              state_d = S_ERR;
            end else begin
              cmd_o.held_in = 1'b1;
              hv_d = 1'b1;
            end
          end else begin
            cmd_o.load1 = 1'b1;
            state_d = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        cmd_o.step  = cnt_q;
        cmd_o.last  = (cnt_q == aescts_pkg::ROUNDS_C);
        if (cnt_q == aescts_pkg::ROUNDS_C) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_DONE: begin
        if (!fin_q) begin
          if (out_free) begin
            cmd_o.out_load  = 1'b1;
            cmd_o.chain_sel = aescts_pkg::CH_AFTER;
            cmd_o.held_cur  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (!pass_q) begin
          // second block of the stolen pair
          cmd_o.load2 = 1'b1;
          pass_d  = 1'b1;
          cnt_d   = 4'd1;
          state_d = S_ROUND;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_EMIT2;
        end
      end
      S_EMIT2: begin
        if (out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = aescts_pkg::OUT_TWO;
          cmd_o.chain_sel = aescts_pkg::CH_IV;
          hv_d    = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = aescts_pkg::OUT_ERR;
          cmd_o.chain_sel = aescts_pkg::CH_IV;
          hv_d    = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (key_wr) begin
      state_d = S_KEXP;
      cnt_d   = 4'd0;
    end
    ov_d = cmd_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_KEXP;
      cnt_q   <= 4'd0;
      fin_q   <= 1'b0;
      pass_q  <= 1'b0;
      hv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      pass_q  <= pass_d;
      hv_q    <= hv_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// ===== rtl/aescts_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescts_dp
// Datapath: config registers, round key store, AES round unit, CBC chain,
// holding register and output register.
// ----------------------------------------------------------------------------
module aescts_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aescts_pkg::dp_cmd_t cmd_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  input  logic [127:0]        in_data_i,
  input  logic [4:0]          in_count_i,
  output logic [127:0]        out_data_o,
  output logic [4:0]          out_bytes_o,
  output logic                out_eom_o,
  output logic                out_status_o
);

  logic [127:0] key_q, iv_q, chain_q, held_q, cur_q, a_q, state_q, kx_q;
  logic         dir_q;
  logic [4:0]   r_q;
  logic [127:0] rk_q [0:aescts_pkg::Rounds];
  logic [127:0] out_q;
  logic [4:0]   ob_q;
  logic         oe_q, os_q;

  logic [3:0]   addr;
  logic [127:0] rk, kx_val, ld1, ld2, cur_pad, merged, ss, is_k, rnd, res_one;

  assign addr    = dir_q ? (aescts_pkg::ROUNDS_C - cmd_i.step) : cmd_i.step;
  assign rk      = rk_q[addr];
  assign kx_val  = (cmd_i.step == 4'd0) ? key_q :
                   aescts_pkg::key_next(kx_q, aescts_pkg::rcon_f(cmd_i.step));
  assign ld1     = dir_q ? held_q : (held_q ^ chain_q);
  assign cur_pad = cur_q & aescts_pkg::byte_mask(r_q);
  // decrypt: tail bytes of the final block come from the stolen block
  assign merged  = cur_pad | (state_q & ~aescts_pkg::byte_mask(r_q));
  assign ld2     = dir_q ? merged : (cur_pad ^ state_q);
  assign ss      = aescts_pkg::sub_shift(state_q);
  assign is_k    = aescts_pkg::inv_sub_shift(state_q) ^ rk;
  assign rnd     = dir_q ? (cmd_i.last ? is_k : aescts_pkg::inv_mix(is_k))
                         : ((cmd_i.last ? ss : aescts_pkg::mix(ss)) ^ rk);
  assign res_one = dir_q ? (state_q ^ chain_q) : state_q;

  // configuration and direction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      iv_q  <= '0;
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aescts_pkg::CFG_KEY_HI: key_q[127:64] <= cfg_data_i;
        aescts_pkg::CFG_KEY_LO: key_q[63:0]   <= cfg_data_i;
        aescts_pkg::CFG_IV_HI:  iv_q[127:64]  <= cfg_data_i;
        aescts_pkg::CFG_IV_LO:  iv_q[63:0]    <= cfg_data_i;
        aescts_pkg::CFG_DIR:    dir_q         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else begin
      case (cmd_i.chain_sel)
        aescts_pkg::CH_AFTER: chain_q <= dir_q ? held_q : state_q;
        aescts_pkg::CH_IV:    chain_q <= iv_q;
        default: ;
      endcase
      if (cfg_we_i && cfg_idx_i == aescts_pkg::CFG_IV_HI) chain_q[127:64] <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == aescts_pkg::CFG_IV_LO) chain_q[63:0]   <= cfg_data_i;
    end
  end

  // round key sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.kx_en) begin
      rk_q[cmd_i.step] <= kx_val;
      kx_q             <= kx_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      cur_q <= in_data_i;
      r_q   <= (in_count_i == 5'd0 || in_count_i > aescts_pkg::FULL_BYTES) ?
               aescts_pkg::FULL_BYTES : in_count_i;
    end
    if (cmd_i.held_in) held_q <= in_data_i;
    else if (cmd_i.held_cur) held_q <= cur_q;
    if (cmd_i.load1) begin
      state_q <= ld1 ^ rk;
    end else if (cmd_i.load2) begin
      state_q <= ld2 ^ rk;
      a_q     <= dir_q ? (state_q ^ ld2) : state_q;
    end else if (cmd_i.round) begin
      state_q <= rnd;
    end
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        aescts_pkg::OUT_TWO: begin
          out_q <= a_q & aescts_pkg::byte_mask(r_q);
          ob_q  <= r_q;
          oe_q  <= 1'b1;
          os_q  <= 1'b0;
        end
        aescts_pkg::OUT_ERR: begin
          out_q <= '0;
          ob_q  <= 5'd0;
          oe_q  <= 1'b1;
          os_q  <= 1'b1;
        end
        default: begin
          out_q <= res_one;
          ob_q  <= aescts_pkg::FULL_BYTES;
          oe_q  <= 1'b0;
          os_q  <= 1'b0;
        end
      endcase
    end
  end

  assign out_data_o   = out_q;
  assign out_bytes_o  = ob_q;
  assign out_eom_o    = oe_q;
  assign out_status_o = os_q;

endmodule
